### hdl/wm2s_pkg.sv
// ----------------------------------------------------------------------------
// wm2s_pkg - shared types and constants
// Widths, limits and the control bundle of the 2-D window minimum core.
// ----------------------------------------------------------------------------
`default_nettype none

package wm2s_pkg;

  localparam int PIXEL_BITS  = 16;
  localparam int MAX_WIN_W   = 32;
  localparam int MAX_WIN_H   = 32;
  localparam int MAX_LINE    = 4096;
  localparam int ROW_LIMIT   = 4096;
  localparam int CNT_BITS    = 12;
  localparam int DIM_BITS    = CNT_BITS + 1;
  localparam int WIN_BITS    = 6;
  localparam int SUM_BITS    = 40;
  localparam int LINE_AW     = $clog2(MAX_LINE);
  localparam int WW_IDX_BITS = $clog2(MAX_WIN_W);
  localparam int WH_IDX_BITS = $clog2(MAX_WIN_H);

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [SUM_BITS-1:0]   sum_t;
  typedef logic [LINE_AW-1:0]    line_addr_t;

  // control bundle shared by every vertical cell
  typedef struct packed {
    logic       rd_en;
    line_addr_t rd_addr;
    logic       wr_en;
    line_addr_t wr_addr;
    logic       hold_en;
    logic       fwd;
  } vctl_t;

endpackage

`default_nettype wire

### hdl/wm2s_ifs.sv
// ----------------------------------------------------------------------------
// wm2s_ifs - stream channels
// Valid/ready channels for pixels in and window results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wm2s_in_if import wm2s_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface wm2s_out_if import wm2s_pkg::*; ();
  logic valid;
  logic ready;
  pix_t window_min;
  sum_t total_sum;
  logic frame_last;

  modport source (output valid, output window_min, output total_sum, output frame_last,
                  input ready);
  modport sink   (input valid, input window_min, input total_sum, input frame_last,
                  output ready);
endinterface

`default_nettype wire

### hdl/window_min_2d_sum_core.sv
// ----------------------------------------------------------------------------
// window_min_2d_sum_core - streaming 2-D window minimum with running sum
// Row of horizontal cells for row minima, row of line-buffered vertical
// cells for column minima, saturating frame sum on the result side.
//
//   channel  | dir | transfer contents
//   ---------+-----+----------------------------------------------
//   in_ch    | in  | pixel
//   out_ch   | out | window_min, total_sum, frame_last
//   cfg (APB)| in  | win_w, win_h, img_w, img_h (4-byte stride)
//
// One pixel per cycle sustained while out_ch is ready; a result reaches the
// output register through the line RAM read with the transfer, the cell
// compare, then window select and sum.
// Stages collapse bubbles, so a pixel is taken while a result waits.
// Synchronous reset clears counters, sum, stage valids and config registers;
// line RAMs are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module window_min_2d_sum_core import wm2s_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  wm2s_in_if.sink          in_ch,
  wm2s_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    REG_WIN_W,
    REG_WIN_H,
    REG_IMG_W,
    REG_IMG_H
  } reg_idx_t;

  // config registers
  logic [WIN_BITS-1:0] win_w_r, win_h_r;
  logic [DIM_BITS-1:0] img_w_r, img_h_r;
  reg_idx_t            reg_idx;
  logic                cfg_wr;

  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r <= WIN_BITS'(1);
      win_h_r <= WIN_BITS'(1);
      img_w_r <= DIM_BITS'(MAX_LINE);
      img_h_r <= DIM_BITS'(ROW_LIMIT);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIN_W: win_w_r <= pwdata[WIN_BITS-1:0];
        REG_WIN_H: win_h_r <= pwdata[WIN_BITS-1:0];
        REG_IMG_W: img_w_r <= pwdata[DIM_BITS-1:0];
        REG_IMG_H: img_h_r <= pwdata[DIM_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIN_W: prdata = 32'(win_w_r);
      REG_WIN_H: prdata = 32'(win_h_r);
      REG_IMG_W: prdata = 32'(img_w_r);
      REG_IMG_H: prdata = 32'(img_h_r);
    endcase
  end

  // effective sizes
  logic [WIN_BITS-1:0]    ww, wh;
  logic [DIM_BITS-1:0]    iw, ih;
  logic [WW_IDX_BITS-1:0] ww_idx;
  logic [WH_IDX_BITS-1:0] wh_idx;

  always_comb begin
    if (win_w_r == '0) ww = WIN_BITS'(1);
    else if (win_w_r > WIN_BITS'(MAX_WIN_W)) ww = WIN_BITS'(MAX_WIN_W);
    else ww = win_w_r;
    if (win_h_r == '0) wh = WIN_BITS'(1);
    else if (win_h_r > WIN_BITS'(MAX_WIN_H)) wh = WIN_BITS'(MAX_WIN_H);
    else wh = win_h_r;
    if (img_w_r == '0) iw = DIM_BITS'(1);
    else if (img_w_r > DIM_BITS'(MAX_LINE)) iw = DIM_BITS'(MAX_LINE);
    else iw = img_w_r;
    if (img_h_r == '0) ih = DIM_BITS'(1);
    else if (img_h_r > DIM_BITS'(ROW_LIMIT)) ih = DIM_BITS'(ROW_LIMIT);
    else ih = img_h_r;
  end

  assign ww_idx = WW_IDX_BITS'(ww - WIN_BITS'(1));
  assign wh_idx = WH_IDX_BITS'(wh - WIN_BITS'(1));

  // stage enables
  logic out_valid_r, s1_valid_r, s2_valid_r;
  logic en_o, en2, en1, acc;

  assign en_o        = !out_valid_r || out_ch.ready;
  assign en2         = en_o || !s2_valid_r;
  assign en1         = en2 || !s1_valid_r;
  assign in_ch.ready = en1;
  assign acc         = in_ch.valid && en1;

  // position counters
  logic [CNT_BITS-1:0] col_r, row_r;
  logic [DIM_BITS-1:0] col_p1, row_p1;
  logic                end_col, end_row, row_ok, emit;

  assign col_p1  = DIM_BITS'(col_r) + DIM_BITS'(1);
  assign row_p1  = DIM_BITS'(row_r) + DIM_BITS'(1);
  assign end_col = col_p1 >= iw;
  assign end_row = row_p1 >= ih;
  assign row_ok  = col_p1 >= DIM_BITS'(ww);
  assign emit    = row_ok && (row_p1 >= DIM_BITS'(wh));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      if (end_col) begin
        col_r <= '0;
        row_r <= end_row ? '0 : row_p1[CNT_BITS-1:0];
      end else begin
        col_r <= col_p1[CNT_BITS-1:0];
      end
    end
  end

  // stage 1: row minimum select, line RAM data, cell compare
  line_addr_t s1_col_r;
  logic       s1_ok_r, s1_emit_r, s1_last_r, s1_fwd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r  <= col_r[LINE_AW-1:0];
      s1_ok_r   <= row_ok;
      s1_emit_r <= emit;
      s1_last_r <= end_col && end_row;
      s1_fwd_r  <= s1_valid_r && s1_ok_r && (s1_col_r == col_r[LINE_AW-1:0]);
    end
  end

  pix_t hm [MAX_WIN_W];

  generate
    for (genvar i = 0; i < MAX_WIN_W; i++) begin : g_h
      if (i == 0) begin : g_first
        wm2s_hcell u_cell (
          .clk  (clk),
          .en   (acc),
          .px   (in_ch.pixel),
          .prev ('1),
          .m    (hm[i])
        );
      end else begin : g_rest
        wm2s_hcell u_cell (
          .clk  (clk),
          .en   (acc),
          .px   (in_ch.pixel),
          .prev (hm[i-1]),
          .m    (hm[i])
        );
      end
    end
  endgenerate

  pix_t  rmin;
  vctl_t vctl;

  assign rmin = hm[ww_idx];

  always_comb begin
    vctl.rd_en   = en1;
    vctl.rd_addr = col_r[LINE_AW-1:0];
    vctl.wr_en   = s1_valid_r && en2 && s1_ok_r;
    vctl.wr_addr = s1_col_r;
    vctl.hold_en = en2;
    vctl.fwd     = s1_fwd_r;
  end

  pix_t line_rd [MAX_WIN_H];
  pix_t vhold   [MAX_WIN_H];

  generate
    for (genvar j = 0; j < MAX_WIN_H; j++) begin : g_v
      if (j == 0) begin : g_first
        wm2s_vcell u_cell (
          .clk       (clk),
          .ctl       (vctl),
          .rmin      (rmin),
          .prev_line ('1),
          .prev_hold ('1),
          .line_rd   (line_rd[j]),
          .hold      (vhold[j])
        );
      end else begin : g_rest
        wm2s_vcell u_cell (
          .clk       (clk),
          .ctl       (vctl),
          .rmin      (rmin),
          .prev_line (line_rd[j-1]),
          .prev_hold (vhold[j-1]),
          .line_rd   (line_rd[j]),
          .hold      (vhold[j])
        );
      end
    end
  endgenerate

  // stage 2: window minimum select and saturating sum
  logic s2_emit_r, s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_emit_r <= s1_emit_r;
      s2_last_r <= s1_last_r;
    end
  end

  pix_t                cmin;
  logic [SUM_BITS:0]   sum_add;
  sum_t                sum_sat, sum_r;

  assign cmin    = vhold[wh_idx];
  assign sum_add = (SUM_BITS+1)'(sum_r) + (SUM_BITS+1)'(cmin);
  assign sum_sat = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (en_o && s2_valid_r) begin
      if (s2_last_r) begin
        sum_r <= '0;
      end else if (s2_emit_r) begin
        sum_r <= sum_sat;
      end
    end
  end

  // output register
  pix_t out_min_r;
  sum_t out_sum_r;
  logic out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_o) begin
      out_valid_r <= s2_valid_r && s2_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && s2_valid_r && s2_emit_r) begin
      out_min_r  <= cmin;
      out_sum_r  <= sum_sat;
      out_last_r <= s2_last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.window_min = out_min_r;
  assign out_ch.total_sum  = out_sum_r;
  assign out_ch.frame_last = out_last_r;

endmodule

`default_nettype wire

### hdl/wm2s_ram.sv
// ----------------------------------------------------------------------------
// wm2s_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wm2s_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/wm2s_hcell.sv
// ----------------------------------------------------------------------------
// wm2s_hcell - horizontal minimum cell
// Holds the minimum of the last k+1 pixels; takes its neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module wm2s_hcell import wm2s_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  wire pix_t px,
  input  wire pix_t prev,
  output pix_t      m
);

  pix_t m_r;
  pix_t m_nxt;

  assign m_nxt = (px < prev) ? px : prev;
  assign m     = m_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/wm2s_vcell.sv
// ----------------------------------------------------------------------------
// wm2s_vcell - vertical minimum cell
// Keeps one line of column minima over k+1 rows and feeds the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module wm2s_vcell import wm2s_pkg::*; (
  input  wire logic  clk,
  input  wire vctl_t ctl,
  input  wire pix_t  rmin,
  input  wire pix_t  prev_line,
  input  wire pix_t  prev_hold,
  output pix_t       line_rd,
  output pix_t       hold
);

  pix_t upper;
  pix_t v_nxt;
  pix_t v_r;

  // previous row's value was written in the same cycle as it was read
  assign upper = ctl.fwd ? prev_hold : prev_line;
  assign v_nxt = (rmin < upper) ? rmin : upper;
  assign hold  = v_r;

  always_ff @(posedge clk) begin
    if (ctl.hold_en) begin
      v_r <= v_nxt;
    end
  end

  wm2s_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_LINE)
  ) u_line (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (ctl.wr_addr),
    .wdata (v_nxt),
    .re    (ctl.rd_en),
    .raddr (ctl.rd_addr),
    .rdata (line_rd)
  );

endmodule

`default_nettype wire
